// ===== sv/plc_pkg.sv =====
//------------------------------------------------------------------------------
// plc_pkg
// Shared types and constants of the positional list engine: opcodes,
// status codes, field widths and the result bundle.
//------------------------------------------------------------------------------
`default_nettype none

package plc_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int DATA_W       = 32;
	localparam int POS_W        = 7;
	localparam int COUNT_W      = 7;
	localparam int OPCODE_W     = 3;
	localparam int STATUS_W     = 2;
	localparam int BEAT_W       = 48;

	typedef enum logic [OPCODE_W-1:0] {
		OP_CLEAR  = 3'd0,
		OP_INSERT = 3'd1,
		OP_DELETE = 3'd2,
		OP_CHANGE = 3'd3,
		OP_FIND   = 3'd4,
		OP_READ   = 3'd5
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_RANGE    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		status_t              status;
		logic [POS_W-1:0]     found_position;
		logic [DATA_W-1:0]    read_value;
		logic [COUNT_W-1:0]   element_count;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/positional_list_engine_core.sv =====
// Positional list engine: keeps an ordered list of up to CAPACITY signed 32-bit
// values in one synchronous RAM and serves one request at a time (clear,
// insert, delete, change, find, read by 1-based position), answering each with
// one result beat. The list is walked through the RAM's single read port, one
// entry per cycle; on insert and delete each entry is written back one place
// up or down in the following cycle. Insert walks positions count down to p,
// delete p+1 up to count, find from the head to its first match; read fetches
// one entry, change writes its entry directly, and clear, unused opcodes and
// errors answer without using the RAM; the longest request is an insert at the
// head of a list of 63 entries. A new request is taken while the previous
// result still waits in the output register. No clearing pass follows reset:
// only entries that were written are ever read.
//------------------------------------------------------------------------------
// positional_list_engine_core
// Top level: request unpacking, sequencer, element store and output register.
//------------------------------------------------------------------------------
`default_nettype none

module positional_list_engine_core #(
	parameter int CAPACITY = plc_pkg::CAPACITY_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// opcode [2:0], position [9:3], data_value [41:10], zero [47:42]
	input  wire logic [plc_pkg::BEAT_W-1:0]    s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// status [1:0], found_position [8:2], read_value [40:9],
	// element_count [47:41]
	output logic      [plc_pkg::BEAT_W-1:0]    m_axis_tdata
);

	localparam int AW = $clog2(CAPACITY);

	plc_pkg::result_t              res;
	logic                          res_valid;
	logic                          res_ready;
	logic                          mem_wr_en;
	logic [AW-1:0]                 mem_wr_addr;
	logic [plc_pkg::DATA_W-1:0]    mem_wr_data;
	logic                          mem_rd_en;
	logic [AW-1:0]                 mem_rd_addr;
	logic [plc_pkg::DATA_W-1:0]    mem_rd_data;
	logic                          out_valid_q;
	logic [plc_pkg::BEAT_W-1:0]    out_data_q;

	plc_seq #(
		.CAPACITY (CAPACITY)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.opcode      (s_axis_tdata[2:0]),
		.position    (s_axis_tdata[9:3]),
		.data_value  (s_axis_tdata[41:10]),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	plc_ram #(
		.WIDTH (plc_pkg::DATA_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// output register takes a result whenever it is empty or its beat is being taken
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= {res.element_count, res.read_value, res.found_position, res.status};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && res_valid))
		else $error("request taken while a result is pending");

	a_result_loads: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> m_axis_tvalid)
		else $error("result not loaded into output register");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == plc_pkg::ST_FULL
		|-> res.element_count == plc_pkg::COUNT_W'(CAPACITY))
		else $error("full reported below capacity");

	a_fpos_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != plc_pkg::ST_OK |-> res.found_position == '0)
		else $error("found position set on failed request");

endmodule

`default_nettype wire

// ===== sv/plc_ram.sv =====
//------------------------------------------------------------------------------
// plc_ram
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read.
//------------------------------------------------------------------------------
`default_nettype none

module plc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/plc_seq.sv =====
//------------------------------------------------------------------------------
// plc_seq
// Request sequencer: checks the request, then walks the element store one
// entry per cycle through the RAM (read, then for insert and delete write back
// one place up or down), and holds the result until it is taken.
//------------------------------------------------------------------------------
`default_nettype none

module plc_seq #(
	parameter int CAPACITY = plc_pkg::CAPACITY_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// request
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [plc_pkg::OPCODE_W-1:0]   opcode,
	input  wire logic [plc_pkg::POS_W-1:0]      position,
	input  wire logic [plc_pkg::DATA_W-1:0]     data_value,
	// result
	output logic                                res_valid,
	input  wire logic                           res_ready,
	output plc_pkg::result_t                    res,
	// element store
	output logic                                mem_wr_en,
	output logic [$clog2(CAPACITY)-1:0]         mem_wr_addr,
	output logic [plc_pkg::DATA_W-1:0]          mem_wr_data,
	output logic                                mem_rd_en,
	output logic [$clog2(CAPACITY)-1:0]         mem_rd_addr,
	input  wire logic [plc_pkg::DATA_W-1:0]     mem_rd_data
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > plc_pkg::POS_W) ? CW : plc_pkg::POS_W) + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FINAL,
		S_DONE
	} state_t;

	state_t                        state_q;
	plc_pkg::opcode_t              op_q;
	logic [CW-1:0]                 cnt_q;
	logic [CW-1:0]                 n_q;
	logic [AW-1:0]                 ptr_q;
	logic [AW-1:0]                 addr_q;
	logic [plc_pkg::DATA_W-1:0]    val_q;
	plc_pkg::status_t              status_q;
	logic [plc_pkg::POS_W-1:0]     fpos_q;
	logic [plc_pkg::DATA_W-1:0]    rval_q;
	logic                          rd_valid_s1;
	logic [AW-1:0]                 rd_addr_s1;

	logic                          accept;
	plc_pkg::opcode_t              op_in;
	logic [XW-1:0]                 pos_x;
	logic [XW-1:0]                 cnt_x;
	logic [XW-1:0]                 pm1_x;
	logic [XW-1:0]                 fpos_x;
	logic                          in_range;
	logic                          ins_range;
	logic                          is_full;
	logic                          walk_more;
	logic                          drained;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign op_in     = plc_pkg::opcode_t'(opcode);
	assign pos_x     = XW'(position);
	assign cnt_x     = XW'(cnt_q);
	assign pm1_x     = pos_x - XW'(1);
	assign in_range  = (position != '0) && (pos_x <= cnt_x);
	assign ins_range = (position != '0) && (pos_x <= cnt_x + XW'(1));
	assign is_full   = (cnt_x == XW'(CAPACITY));
	assign walk_more = (n_q != '0);
	assign drained   = !walk_more && !rd_valid_s1;
	assign fpos_x    = XW'(rd_addr_s1) + XW'(1);

	assign res_valid          = (state_q == S_DONE);
	assign res.status         = status_q;
	assign res.found_position = fpos_q;
	assign res.read_value     = rval_q;
	assign res.element_count  = cnt_x[plc_pkg::COUNT_W-1:0];

	assign mem_rd_en   = (state_q == S_WALK) && walk_more;
	assign mem_rd_addr = ptr_q;

	// shifting writes use the address of the registered read (rd_addr_s1), so read and write never hit one entry
	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = addr_q;
		mem_wr_data = val_q;
		if (state_q == S_FINAL) begin
			mem_wr_en = 1'b1;
		end else if (state_q == S_WALK && rd_valid_s1) begin
			mem_wr_data = mem_rd_data;
			if (op_q == plc_pkg::OP_INSERT) begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = rd_addr_s1 + AW'(1);
			end else if (op_q == plc_pkg::OP_DELETE) begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = rd_addr_s1 - AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			n_q         <= '0;
			rd_valid_s1 <= 1'b0;
			op_q        <= plc_pkg::OP_CLEAR;
			ptr_q       <= '0;
			addr_q      <= '0;
			val_q       <= '0;
			status_q    <= plc_pkg::ST_OK;
			fpos_q      <= '0;
			rval_q      <= '0;
			rd_addr_s1  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q        <= op_in;
						val_q       <= data_value;
						addr_q      <= AW'(pm1_x);
						status_q    <= plc_pkg::ST_OK;
						fpos_q      <= '0;
						rval_q      <= '0;
						rd_valid_s1 <= 1'b0;
						n_q         <= '0;
						state_q     <= S_DONE;
						unique case (op_in)
							plc_pkg::OP_CLEAR: begin
								cnt_q <= '0;
							end
							plc_pkg::OP_INSERT: begin
								if (!ins_range) begin
									status_q <= plc_pkg::ST_RANGE;
								end else if (is_full) begin
									status_q <= plc_pkg::ST_FULL;
								end else begin
									// move entries count-1 down to pos-1, top first
									n_q     <= CW'(cnt_x - pm1_x);
									ptr_q   <= AW'(cnt_x - XW'(1));
									state_q <= S_WALK;
								end
							end
							plc_pkg::OP_DELETE: begin
								if (!in_range) begin
									status_q <= plc_pkg::ST_RANGE;
								end else begin
									n_q     <= CW'(cnt_x - pos_x);
									ptr_q   <= AW'(pos_x);
									state_q <= S_WALK;
								end
							end
							plc_pkg::OP_CHANGE: begin
								if (!in_range) begin
									status_q <= plc_pkg::ST_RANGE;
								end else begin
									state_q <= S_FINAL;
								end
							end
							plc_pkg::OP_FIND: begin
								status_q <= plc_pkg::ST_NOTFOUND;
								n_q      <= cnt_q;
								ptr_q    <= '0;
								state_q  <= S_WALK;
							end
							plc_pkg::OP_READ: begin
								if (!in_range) begin
									status_q <= plc_pkg::ST_RANGE;
								end else begin
									n_q     <= CW'(1);
									ptr_q   <= AW'(pm1_x);
									state_q <= S_WALK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_WALK: begin
					if (walk_more) begin
						ptr_q <= (op_q == plc_pkg::OP_INSERT) ? ptr_q - AW'(1) : ptr_q + AW'(1);
						n_q   <= n_q - CW'(1);
					end
					rd_valid_s1 <= walk_more;
					rd_addr_s1  <= ptr_q;
					if (drained) begin
						if (op_q == plc_pkg::OP_INSERT) begin
							state_q <= S_FINAL;
						end else begin
							if (op_q == plc_pkg::OP_DELETE) begin
								cnt_q <= cnt_q - CW'(1);
							end
							state_q <= S_DONE;
						end
					end else if (rd_valid_s1) begin
						// first match ends the search
						if (op_q == plc_pkg::OP_FIND && mem_rd_data == val_q) begin
							status_q    <= plc_pkg::ST_OK;
							fpos_q      <= fpos_x[plc_pkg::POS_W-1:0];
							rd_valid_s1 <= 1'b0;
							state_q     <= S_DONE;
						end else if (op_q == plc_pkg::OP_READ) begin
							rval_q      <= mem_rd_data;
							rd_valid_s1 <= 1'b0;
							state_q     <= S_DONE;
						end
					end
				end
				S_FINAL: begin
					if (op_q == plc_pkg::OP_INSERT) begin
						cnt_q <= cnt_q + CW'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
